// ===== rtl/fet_pkg.sv =====
// fet_pkg: payload structs and status codes for the free extent table.
// No dependencies.
package fet_pkg;
	typedef struct packed {
		logic       op;
		logic [7:0] addr;
		logic [8:0] size;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] largest_free;
		logic [4:0] extent_count;
	} out_item_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_EXT  = 2'd1;
	localparam logic [1:0] ST_TOO_BIG = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;
endpackage

// ===== rtl/fet_mem.sv =====
// fet_mem: extent table storage, one write and one registered read port.
// Depends on nothing.
module fet_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 25
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/free_extent_table.sv =====
// free_extent_table: top level. Table of free heap extents ordered by start.
// Uses fet_pkg and fet_mem (a ping-pong pair of tables).
//
// Usage: one input channel (in_valid/in_ready/in_data) carrying op, addr and
// size, one output channel (out_valid/out_ready/out_data) carrying status,
// largest free length and extent count. One result per transfer in.
// Items are processed one at a time. Allocation streams the current table
// through a memory read and writes a new copy into the other bank, dropping
// or adjusting the hit entry; a free streams the table once, inserting the
// new region in order and merging touching neighbours on the fly.
// A free that inserts nothing skips the table pass. The pass length is set by
// the single read port of the active bank plus the insertion and final flush
// of a free.
// An unsuccessful item leaves the active bank unchanged (the scratch copy is
// discarded). The result sits in an output register; the next item is taken
// the cycle after that result's transfer, so a stalled receiver simply holds
// the block after it has finished. Reset empties the table at once (count
// zero); table contents need no clearing.
module free_extent_table #(
	parameter int HEAP_SIZE   = 256,
	parameter int MAX_EXTENTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fet_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fet_pkg::out_item_t out_data
);
	localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 2);
	localparam int HW = $clog2(HEAP_SIZE + 1);
	localparam int DW = 8 + 9;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_TAIL = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic          bank_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] rd_q;     // entries requested
	logic [CW-1:0] nout_q;   // entries written to scratch
	logic          rvalid_s1;
	fet_pkg::in_item_t item_q;
	logic [HW-1:0] fsize_q;
	logic          placed_q, hit_q, err_q;
	logic [1:0]    status_q;
	logic          pend_q;   // merge accumulator holds an extent
	logic [8:0]    pst_q;
	logic [HW-1:0] plen_q;
	logic [8:0]    big_q;
	logic [8:0]    bigold_q;
	logic          out_valid_q;
	fet_pkg::out_item_t out_q;

	logic [DW-1:0] rdata0, rdata1, rdata, wdata;
	logic          we;
	logic [AW-1:0] waddr, raddr;

	// one merge step: next candidate extent (from table or the new region)
	logic          c_valid;
	logic [8:0]    c_st;
	logic [HW-1:0] c_len;
	logic          c_is_new;
	logic          emit;
	logic [8:0]    emit_st;
	logic [HW-1:0] emit_len;
	logic          can_new;

	fet_mem #(.DEPTH(MAX_EXTENTS), .AW(AW), .DW(DW)) u_bank0 (
		.clk(clk), .we(we && bank_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata0));
	fet_mem #(.DEPTH(MAX_EXTENTS), .AW(AW), .DW(DW)) u_bank1 (
		.clk(clk), .we(we && !bank_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata1));

	// re-read the current entry while the new region is inserted ahead of it
	assign rdata    = bank_q ? rdata1 : rdata0;
	assign raddr    = (c_valid && c_is_new) ? AW'(rd_q - 1'b1) : rd_q[AW-1:0];
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// clipped free length of the incoming item, zero when nothing is inserted
	logic [HW-1:0] room_in, fsize_in;
	logic          noop_in;
	assign room_in = HW'(HEAP_SIZE) - HW'(in_data.addr);
	always_comb begin
		if (in_data.size == '0 || HW'(in_data.addr) >= HW'(HEAP_SIZE))
			fsize_in = '0;
		else if ({1'b0, in_data.size} > {1'b0, room_in})
			fsize_in = room_in;
		else
			fsize_in = HW'(in_data.size);
	end
	assign noop_in = in_data.op == fet_pkg::OP_FREE && fsize_in == '0;

	// result keeps the old table: error, full table or empty free
	logic full_c, keep_c;
	assign full_c = item_q.op == fet_pkg::OP_FREE && nout_q > CW'(MAX_EXTENTS);
	assign keep_c = err_q || full_c;

	// current streamed entry
	logic [7:0] e_st;
	logic [8:0] e_len;
	assign e_st  = rdata[16:9];
	assign e_len = rdata[8:0];

	always_comb begin
		can_new    = item_q.op == fet_pkg::OP_FREE && !placed_q && fsize_q != '0;
		c_valid    = 1'b0;
		c_is_new   = 1'b0;
		c_st       = '0;
		c_len      = '0;
		if (state_q == S_RUN && rvalid_s1) begin
			if (can_new && {1'b0, e_st} > {1'b0, item_q.addr}) begin
				c_valid = 1'b1; c_is_new = 1'b1;
				c_st = {1'b0, item_q.addr}; c_len = fsize_q;
			end else begin
				c_valid = 1'b1;
				c_st = {1'b0, e_st}; c_len = HW'(e_len);
			end
		end else if (state_q == S_TAIL && can_new) begin
			c_valid = 1'b1; c_is_new = 1'b1;
			c_st = {1'b0, item_q.addr}; c_len = fsize_q;
		end
	end

	// alloc per-entry decision
	logic          a_hit;
	logic [8:0]    a_rem;
	assign a_hit = !hit_q && e_st == item_q.addr;
	assign a_rem = e_len - item_q.size;

	always_comb begin
		we       = 1'b0;
		waddr    = nout_q[AW-1:0];
		wdata    = '0;
		emit     = 1'b0;
		emit_st  = '0;
		emit_len = '0;
		if (item_q.op == fet_pkg::OP_ALLOC) begin
			if (state_q == S_RUN && rvalid_s1) begin
				if (a_hit) begin
					if (item_q.size <= e_len && a_rem != '0) begin
						we = 1'b1;
						wdata = {8'(e_st + item_q.size[7:0]), a_rem};
					end
				end else begin
					we = 1'b1; wdata = rdata;
				end
			end
		end else if (c_valid) begin
			if (pend_q && (pst_q + 9'(plen_q)) == c_st) begin
				emit = 1'b0;
			end else if (pend_q) begin
				emit = 1'b1; emit_st = pst_q; emit_len = plen_q;
			end
		end else if (state_q == S_TAIL && pend_q && !can_new) begin
			emit = 1'b1; emit_st = pst_q; emit_len = plen_q;
		end
		if (emit && nout_q < CW'(MAX_EXTENTS)) begin
			we = 1'b1; wdata = {emit_st[7:0], 9'(emit_len)};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			used_q      <= '0;
			rd_q        <= '0;
			nout_q      <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			placed_q    <= 1'b0;
			hit_q       <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						item_q    <= in_data;
						fsize_q   <= fsize_in;
						rd_q      <= '0;
						nout_q    <= '0;
						placed_q  <= 1'b0;
						hit_q     <= 1'b0;
						err_q     <= noop_in;
						pend_q    <= 1'b0;
						status_q  <= fet_pkg::ST_OK;
						big_q     <= '0;
						rvalid_s1 <= 1'b0;
						state_q   <= noop_in ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					// issue reads, stall the read pointer when new region inserts
					if (!(c_valid && c_is_new)) begin
						if (rd_q < used_q) begin
							rd_q <= rd_q + 1'b1;
							rvalid_s1 <= 1'b1;
						end else begin
							rvalid_s1 <= 1'b0;
						end
					end
					if (item_q.op == fet_pkg::OP_ALLOC) begin
						if (rvalid_s1) begin
							if (a_hit) begin
								hit_q <= 1'b1;
								if (item_q.size > e_len) begin
									err_q <= 1'b1; status_q <= fet_pkg::ST_TOO_BIG;
								end
							end
							if (we) begin
								nout_q <= nout_q + 1'b1;
								if ((a_hit ? a_rem : e_len) > big_q)
									big_q <= a_hit ? a_rem : e_len;
							end
						end
					end
					if (rd_q == used_q && !rvalid_s1)
						state_q <= S_TAIL;
				end
				S_TAIL: begin
					if (item_q.op == fet_pkg::OP_ALLOC) begin
						state_q <= S_DONE;
						if (!hit_q) begin
							err_q <= 1'b1; status_q <= fet_pkg::ST_NO_EXT;
						end
					end else if (!can_new && !pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						if (keep_c) begin
							out_q.status <= full_c ? fet_pkg::ST_FULL : status_q;
							out_q.largest_free <= bigold_q;
							out_q.extent_count <= 5'(used_q);
						end else begin
							out_q.status <= fet_pkg::ST_OK;
							out_q.largest_free <= big_q;
							out_q.extent_count <= 5'(nout_q);
							used_q <= nout_q;
							bank_q <= !bank_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// merge accumulator for frees
			if (item_q.op == fet_pkg::OP_FREE && state_q != S_IDLE && state_q != S_DONE) begin
				if (c_valid) begin
					if (c_is_new) placed_q <= 1'b1;
					if (pend_q && (pst_q + 9'(plen_q)) == c_st) begin
						plen_q <= plen_q + c_len;
					end else begin
						pst_q <= c_st; plen_q <= c_len; pend_q <= 1'b1;
					end
				end else if (state_q == S_TAIL && pend_q && !can_new) begin
					pend_q <= 1'b0;
				end
				if (emit) begin
					nout_q <= nout_q + 1'b1;
					if (9'(emit_len) > big_q) big_q <= 9'(emit_len);
				end
			end
		end
	end

	// largest extent of the table before the step, kept for error results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bigold_q <= '0;
		else if (state_q == S_DONE && !out_valid_q && !keep_c)
			bigold_q <= big_q;
	end

	// table count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_EXTENTS))
		else $error("extent count above capacity");
	// new item only taken when idle with output free
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_RUN || state_q == S_DONE))
		else $error("item accepted outside idle");
	// bank flips only on a completed item
	assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q != $past(bank_q)) |-> $rose(out_valid_q))
		else $error("bank swap without result");
endmodule
